[rtl/tsdt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsdt_pkg
// Shared types and constants of the topology source duplicate table.
// ----------------------------------------------------------------------------
package tsdt_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // field widths
    localparam int ADDR_W  = 32;
    localparam int SEQ_W   = 16;
    localparam int LIFE_W  = 8;
    localparam int CFG_W   = 32;

    // stream word widths
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 40;

    // command queue between front and back, power of two
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    // register reset values
    localparam logic [ADDR_W-1:0] OWN_ADDR_RST  = '0;
    localparam logic [SEQ_W-1:0]  SEQ_THR_RST   = 16'd100;
    localparam logic [SEQ_W-1:0]  MAX_SEQ_RST   = 16'hFFFF;
    localparam logic [LIFE_W-1:0] LIFE_TIME_RST = 8'd5;

    // register indexes
    typedef enum logic [1:0] {
        REG_OWN_ADDR = 2'd0,
        REG_SEQ_THR  = 2'd1,
        REG_MAX_SEQ  = 2'd2,
        REG_LIFE     = 2'd3
    } cfg_idx_t;

    // verdict codes
    typedef enum logic [1:0] {
        ST_NEW    = 2'd0,
        ST_UPDATE = 2'd1,
        ST_STALE  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // result kinds
    typedef enum logic {
        KIND_VERDICT = 1'b0,
        KIND_REMOVE  = 1'b1
    } kind_t;

    // configuration register set
    typedef struct packed {
        logic [ADDR_W-1:0] own_addr;
        logic [SEQ_W-1:0]  seq_threshold;
        logic [SEQ_W-1:0]  max_seq;
        logic [LIFE_W-1:0] life_time;
    } cfg_t;

    // classified message handed from front to back
    typedef struct packed {
        logic [ADDR_W-1:0] src;
        logic [SEQ_W-1:0]  seq;
        logic              self;
        logic              hit;
        logic [IDX_W-1:0]  hit_idx;
        logic              full;
        logic [IDX_W-1:0]  free_idx;
    } cmd_t;

    // table contents seen by the front lookup
    typedef struct packed {
        logic [TABLE_DEPTH-1:0]             valid;
        logic [TABLE_DEPTH-1:0][ADDR_W-1:0] addr;
    } table_view_t;

endpackage

[rtl/topology_source_dedup_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// topology_source_dedup_table
// Duplicate suppression table for topology messages keyed by originator.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  s_axis    in         tvalid / tready         source_addr, seq_num, from_addr
//  m_axis    out        tvalid / tready         verdict or removal, tlast, tuser
//  cfg       in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  Input register, command queue and back-end fetch come before the check
//  step, which loads the output register. A held input word is issued only
//  while the queue is empty and the back end idle, so commands never overlap.
//  An aging pass with removals then walks one slot a cycle up to the highest
//  removed slot. Reset clears all valid bits at once. A stalled output
//  register holds the check or scan step.
// ----------------------------------------------------------------------------
module topology_source_dedup_table
    import tsdt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // source_addr[31:0], seq_num[47:32], from_addr[79:48]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status[1:0], forward[2], node_addr[34:3], zero fill[39:35]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // kind[0]
    output logic                  m_axis_tuser,
    output logic                  m_axis_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    cfg_t        cfg_reg;
    table_view_t view;
    cmd_t        push_cmd, head;
    logic        push, pop, q_empty, q_full, back_idle;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_addr      <= OWN_ADDR_RST;
            cfg_reg.seq_threshold <= SEQ_THR_RST;
            cfg_reg.max_seq       <= MAX_SEQ_RST;
            cfg_reg.life_time     <= LIFE_TIME_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_OWN_ADDR: cfg_reg.own_addr      <= cfg_data;
                REG_SEQ_THR:  cfg_reg.seq_threshold <= cfg_data[SEQ_W-1:0];
                REG_MAX_SEQ:  cfg_reg.max_seq       <= cfg_data[SEQ_W-1:0];
                REG_LIFE:     cfg_reg.life_time     <= cfg_data[LIFE_W-1:0];
                default:      cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // front: input register and lookup
    tsdt_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .cfg           (cfg_reg),
        .view          (view),
        .queue_empty   (q_empty),
        .back_idle     (back_idle),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    // command queue
    tsdt_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    // back: table update, aging and results
    tsdt_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .cmd_valid     (!q_empty),
        .cmd           (head),
        .cmd_pop       (pop),
        .back_idle     (back_idle),
        .view          (view),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // lookup only against a quiet table
    a_issue_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (back_idle && q_empty && !q_full))
        else $error("command issued while the table was changing");

    // a queued command is picked up by an idle back end
    a_pickup: assert property (@(posedge clk) disable iff (!rst_n)
        (back_idle && !q_empty) |=> !back_idle)
        else $error("idle back end left a command waiting");

    // removal words carry no verdict
    a_remove_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_REMOVE)) |-> (m_axis_tdata[2:0] == 3'b000))
        else $error("removal word with verdict bits set");

endmodule

[rtl/tsdt_cmd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsdt_cmd_queue
// Short queue of classified commands between the front and the back.
// ----------------------------------------------------------------------------
module tsdt_cmd_queue
    import tsdt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic empty,
    output logic full
);

    cmd_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    // occupancy flags
    assign empty   = (count_reg == '0);
    assign full    = (count_reg == (QPTR_W + 1)'(QDEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = q_reg[rd_ptr_reg];

    // pointer and count update, pointers wrap at the power-of-two depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/tsdt_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsdt_front
// Input word register and originator lookup; issues classified commands.
// ----------------------------------------------------------------------------
module tsdt_front
    import tsdt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    input  cfg_t                 cfg,
    input  table_view_t          view,
    input  logic                 queue_empty,
    input  logic                 back_idle,
    output logic                 push,
    output cmd_t                 push_cmd
);

    logic [ADDR_W-1:0] src_reg;
    logic [SEQ_W-1:0]  seq_reg;
    logic [ADDR_W-1:0] from_reg;
    logic              full_reg, full_next;
    logic              accept;
    logic              hit, found_free;
    logic [IDX_W-1:0]  hit_idx, free_idx;

    // a command leaves only when the table is quiet, so the lookup is exact
    assign push          = full_reg && queue_empty && back_idle;
    assign s_axis_tready = !full_reg || push;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // first matching valid slot and lowest free slot
    always_comb
    begin
        hit        = 1'b0;
        hit_idx    = '0;
        found_free = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (view.valid[i])
            begin
                if (!hit && (view.addr[i] == src_reg))
                begin
                    hit     = 1'b1;
                    hit_idx = IDX_W'(i);
                end
            end
            else if (!found_free)
            begin
                found_free = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // classified command
    always_comb
    begin
        push_cmd.src      = src_reg;
        push_cmd.seq      = seq_reg;
        push_cmd.self     = (from_reg == cfg.own_addr);
        push_cmd.hit      = hit;
        push_cmd.hit_idx  = hit_idx;
        push_cmd.full     = !hit && !found_free;
        push_cmd.free_idx = free_idx;
    end

    // holding register occupancy
    always_comb
    begin
        full_next = full_reg;
        if (accept)
        begin
            full_next = 1'b1;
        end
        else if (push)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    // input word fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            src_reg  <= s_axis_tdata[31:0];
            seq_reg  <= s_axis_tdata[47:32];
            from_reg <= s_axis_tdata[79:48];
        end
    end

endmodule

[rtl/tsdt_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsdt_back
// Table storage, verdict and update, aging pass and removal reporting.
// ----------------------------------------------------------------------------
module tsdt_back
    import tsdt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  cmd_valid,
    input  cmd_t                  cmd,
    output logic                  cmd_pop,
    output logic                  back_idle,
    output table_view_t           view,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tuser,
    output logic                  m_axis_tlast
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN
    } state_t;

    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [TABLE_DEPTH-1:0] mask_reg, mask_next;
    logic [IDX_W-1:0]       scan_reg, scan_next;

    logic [ADDR_W-1:0] entry_addr_reg  [TABLE_DEPTH];
    logic [SEQ_W-1:0]  entry_seq_reg   [TABLE_DEPTH];
    logic [LIFE_W-1:0] entry_count_reg [TABLE_DEPTH];
    logic [LIFE_W-1:0] entry_count_next[TABLE_DEPTH];

    logic              out_valid_reg, out_valid_next;
    kind_t             out_kind_reg, out_kind_next;
    status_t           out_status_reg, out_status_next;
    logic              out_fwd_reg, out_fwd_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic              out_last_reg, out_last_next;

    logic                   out_free;
    logic [SEQ_W-1:0]       stored_seq;
    logic signed [SEQ_W+1:0] limit;
    logic                   stale, accepted, aging, commit;
    logic [IDX_W-1:0]       target;
    status_t                verdict;
    logic [TABLE_DEPTH-1:0] age_mask;
    logic [TABLE_DEPTH-1:0] scan_bit;
    logic                   ent_v;
    logic [LIFE_W-1:0]      ent_c;

    assign back_idle = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign scan_bit  = TABLE_DEPTH'(1) << scan_reg;

    // table view for the front lookup
    always_comb
    begin
        view.valid = valid_reg;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            view.addr[i] = entry_addr_reg[i];
        end
    end

    // sequence window: below the threshold the window wraps past max_seq
    always_comb
    begin
        stored_seq = entry_seq_reg[cmd_reg.hit_idx];
        limit      = $signed({2'b00, cfg.max_seq}) + $signed({2'b00, stored_seq})
                     - $signed({2'b00, cfg.seq_threshold});
        if (stored_seq < cfg.seq_threshold)
        begin
            stale = (cmd_reg.seq <= stored_seq)
                    || ($signed({2'b00, cmd_reg.seq}) > limit);
        end
        else
        begin
            stale = (cmd_reg.seq <= stored_seq);
        end
        stale = stale && cmd_reg.hit;
    end

    // verdict
    always_comb
    begin
        accepted = !cmd_reg.full && !stale;
        aging    = accepted && cmd_reg.self;
        target   = cmd_reg.hit ? cmd_reg.hit_idx : cmd_reg.free_idx;
        if (cmd_reg.full)
        begin
            verdict = ST_FULL;
        end
        else if (stale)
        begin
            verdict = ST_STALE;
        end
        else if (cmd_reg.hit)
        begin
            verdict = ST_UPDATE;
        end
        else
        begin
            verdict = ST_NEW;
        end
    end

    // sequencer, output register and table control
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        valid_next      = valid_reg;
        mask_next       = mask_reg;
        scan_next       = scan_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_kind_next   = out_kind_reg;
        out_status_next = out_status_reg;
        out_fwd_next    = out_fwd_reg;
        out_addr_next   = out_addr_reg;
        out_last_next   = out_last_reg;
        cmd_pop         = 1'b0;
        commit          = 1'b0;
        age_mask        = '0;
        ent_v           = 1'b0;
        ent_c           = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            entry_count_next[i] = entry_count_reg[i];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (out_free)
                begin
                    commit = accepted;
                    // update and aging of every slot in one step
                    for (int i = 0; i < TABLE_DEPTH; i++)
                    begin
                        ent_v = valid_reg[i];
                        ent_c = entry_count_reg[i];
                        if (accepted && (IDX_W'(i) == target))
                        begin
                            ent_v = 1'b1;
                            ent_c = cfg.life_time;
                        end
                        if (aging && ent_v)
                        begin
                            if (ent_c == LIFE_W'(1))
                            begin
                                age_mask[i] = 1'b1;
                                ent_v       = 1'b0;
                            end
                            else
                            begin
                                ent_c = ent_c - 1'b1;
                            end
                        end
                        valid_next[i]       = ent_v;
                        entry_count_next[i] = ent_c;
                    end
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_VERDICT;
                    out_status_next = verdict;
                    out_fwd_next    = accepted && !cmd_reg.self;
                    out_addr_next   = cmd_reg.src;
                    out_last_next   = (age_mask == '0);
                    mask_next       = age_mask;
                    scan_next       = '0;
                    state_next      = (age_mask == '0) ? S_IDLE : S_SCAN;
                end
            end

            S_SCAN:
            begin
                // one slot a cycle, held on a removed slot while the output is stalled; removed slots reported in order
                if (!mask_reg[scan_reg])
                begin
                    scan_next = scan_reg + 1'b1;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_REMOVE;
                    out_status_next = ST_NEW;
                    out_fwd_next    = 1'b0;
                    out_addr_next   = entry_addr_reg[scan_reg];
                    out_last_next   = ((mask_reg & ~scan_bit) == '0);
                    mask_next       = mask_reg & ~scan_bit;
                    scan_next       = scan_reg + 1'b1;
                    if ((mask_reg & ~scan_bit) == '0)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= '0;
            valid_reg      <= '0;
            mask_reg       <= '0;
            scan_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= KIND_VERDICT;
            out_status_reg <= ST_NEW;
            out_fwd_reg    <= 1'b0;
            out_addr_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            valid_reg      <= valid_next;
            mask_reg       <= mask_next;
            scan_reg       <= scan_next;
            out_valid_reg  <= out_valid_next;
            out_kind_reg   <= out_kind_next;
            out_status_reg <= out_status_next;
            out_fwd_reg    <= out_fwd_next;
            out_addr_reg   <= out_addr_next;
            out_last_reg   <= out_last_next;
        end
    end

    // table storage
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            entry_count_reg[i] <= entry_count_next[i];
        end
        if (commit)
        begin
            entry_addr_reg[target] <= cmd_reg.src;
            entry_seq_reg[target]  <= cmd_reg.seq;
        end
    end

    // result word
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - ADDR_W - 3)'(0), out_addr_reg, out_fwd_reg,
                            out_status_reg};

endmodule
